FILE: rtl/core/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, types and controller/datapath command structs for the
// RC4 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  // Permutation box geometry
  localparam int unsigned BOX_DEPTH = 256;
  localparam int unsigned BOX_AW    = 8;
  localparam logic [BOX_AW-1:0] BOX_LAST = 8'hff;

  // Key store geometry
  localparam int unsigned KEY_DEPTH  = 256;
  localparam int unsigned KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned KEY_CNT_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH + 1) : 1;

  // Item kinds
  typedef enum logic {
    ACT_KEY   = 1'b0,
    ACT_CRYPT = 1'b1
  } action_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCH_RD,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic key_store;
    logic sched_start;
    logic crypt_start;
    logic sched_read;
    logic read_b;
    logic add_key;
    logic write_a;
    logic write_b;
    logic sched_step;
    logic sched_end;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_step;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/rc4_if.sv
// ----------------------------------------------------------------------------
// rc4_if
// Valid/ready channel interfaces for the RC4 engine input and result streams.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       last_item;

  modport source (output valid, output action, output data_byte, output last_item,
                  input ready);
  modport sink   (input valid, input action, input data_byte, input last_item,
                  output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for the RC4 engine: walks the read/read/write/write swap step
// for both the generator and each round of the key schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          din_valid,
  input  wire logic          din_action,
  input  wire logic          din_last,
  output logic               din_ready,
  input  wire rc4_pkg::sts_t sts,
  output rc4_pkg::cmd_t      cmd
);
  import rc4_pkg::*;

  state_t state, state_next;
  logic   sched, sched_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sched <= 1'b0;
    end else begin
      state <= state_next;
      sched <= sched_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    sched_next = sched;
    cmd        = '0;
    din_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        din_ready = ~rst;
        if (din_valid && !rst) begin
          if (din_action == ACT_KEY) begin
            cmd.key_store = 1'b1;
            if (din_last) begin
              cmd.sched_start = 1'b1;
              sched_next      = 1'b1;
              state_next      = ST_SCH_RD;
            end
          end else begin
            cmd.crypt_start = 1'b1;
            state_next      = ST_RD_B;
          end
        end
      end
      ST_SCH_RD: begin
        cmd.sched_read = 1'b1;
        state_next     = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.read_b  = 1'b1;
        cmd.add_key = sched;
        state_next  = ST_WR_A;
      end
      ST_WR_A: begin
        cmd.write_a = 1'b1;
        state_next  = ST_WR_B;
      end
      ST_WR_B: begin
        cmd.write_b = 1'b1;
        if (sched) begin
          cmd.sched_step = 1'b1;
          if (sts.last_step) begin
            cmd.sched_end = 1'b1;
            sched_next    = 1'b0;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_SCH_RD;
          end
        end else if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        sched_next = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_sched_enters: assert property (@(posedge clk) disable iff (rst)
    cmd.sched_start |=> (state == ST_SCH_RD && sched))
    else $error("schedule did not start after last key byte");

  a_sched_loops: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR_B && sched && !sts.last_step) |=> (state == ST_SCH_RD))
    else $error("schedule round did not continue");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR_B && !sched && !sts.out_free) |=> (state == ST_WR_B))
    else $error("crypt result dropped while output busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rc4_dp.sv
// ----------------------------------------------------------------------------
// rc4_dp
// Datapath for the RC4 engine: box RAM with per-entry valid bits (invalid
// entries read as identity), key RAM, generator indices and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rc4_pkg::cmd_t cmd,
  output rc4_pkg::sts_t      sts,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_item,
  input  wire logic          dout_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import rc4_pkg::*;

  // Index and counter state
  logic [BOX_AW-1:0]    idx_a;
  logic [BOX_AW-1:0]    idx_j;
  logic [KEY_AW-1:0]    key_idx;
  logic [KEY_CNT_W-1:0] key_count;
  logic [BOX_DEPTH-1:0] box_vld;

  // Payload registers
  logic [7:0]        val_a;
  logic [7:0]        val_b;
  logic [7:0]        data_q;
  logic              last_q;
  logic              eq_a;
  logic              eq_j;
  logic [BOX_AW-1:0] box_addr_q;
  logic              box_vld_q;

  // RAM ports
  logic              box_we, box_re;
  logic [BOX_AW-1:0] box_waddr, box_raddr;
  logic [7:0]        box_wdata, box_ram_q, box_dat;
  logic              key_we;
  logic [7:0]        key_dat;

  logic [7:0]           key_add;
  logic [BOX_AW-1:0]    j_sum;
  logic [KEY_CNT_W-1:0] key_idx_inc;
  logic                 key_room;
  logic [7:0]           ks;

  // Unwritten box entries read as their own address
  assign box_dat = box_vld_q ? box_ram_q : box_addr_q;

  assign key_add = cmd.add_key ? key_dat : 8'd0;
  assign j_sum   = idx_j + box_dat + key_add;

  // Box read address
  always_comb begin
    box_re    = 1'b1;
    box_raddr = idx_a;
    priority if (cmd.crypt_start) begin
      box_raddr = idx_a + BOX_AW'(1);
    end else if (cmd.sched_read) begin
      box_raddr = idx_a;
    end else if (cmd.read_b) begin
      box_raddr = j_sum;
    end else if (cmd.write_a) begin
      box_raddr = val_a + box_dat;
    end else begin
      box_re = 1'b0;
    end
  end

  // Box write: first leg writes b at a, second writes a at j
  always_comb begin
    box_we    = cmd.write_a | cmd.write_b;
    box_waddr = cmd.write_a ? idx_a : idx_j;
    box_wdata = cmd.write_a ? box_dat : val_a;
  end

  rc4_ram #(.WIDTH(8), .DEPTH(BOX_DEPTH)) u_box_ram (
    .clk   (clk),
    .we    (box_we),
    .waddr (box_waddr),
    .wdata (box_wdata),
    .re    (box_re),
    .raddr (box_raddr),
    .rdata (box_ram_q)
  );

  // Key store, written in arrival order until full
  assign key_room = key_count < KEY_CNT_W'(KEY_DEPTH);
  assign key_we   = cmd.key_store & key_room;

  rc4_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_count[KEY_AW-1:0]),
    .wdata (data_byte),
    .re    (cmd.sched_read),
    .raddr (key_idx),
    .rdata (key_dat)
  );

  // Valid bits: cleared to identity at reset and schedule start, set on each write
  always_ff @(posedge clk) begin
    if (rst || cmd.sched_start) begin
      box_vld <= '0;
    end else if (box_we) begin
      box_vld[box_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (box_re) begin
      box_addr_q <= box_raddr;
      box_vld_q  <= box_vld[box_raddr];
    end
  end

  // Generator / schedule indices
  assign key_idx_inc = KEY_CNT_W'(key_idx) + KEY_CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_a     <= '0;
      idx_j     <= '0;
      key_idx   <= '0;
      key_count <= '0;
    end else begin
      if (cmd.sched_start) begin
        idx_a <= '0;
      end else if (cmd.crypt_start || cmd.sched_step) begin
        idx_a <= idx_a + BOX_AW'(1);
      end

      if (cmd.sched_start || cmd.sched_end) begin
        idx_j <= '0;
      end else if (cmd.read_b) begin
        idx_j <= j_sum;
      end

      // Key index cycles over the stored key length
      if (cmd.sched_start) begin
        key_idx <= '0;
      end else if (cmd.sched_step) begin
        key_idx <= (key_idx_inc == key_count) ? '0 : KEY_AW'(key_idx_inc);
      end

      if (cmd.sched_end) begin
        key_count <= '0;
      end else if (key_we) begin
        key_count <= key_count + KEY_CNT_W'(1);
      end
    end
  end

  // Swap operands, crypt item payload and keystream forwarding flags
  always_ff @(posedge clk) begin
    if (cmd.crypt_start) begin
      data_q <= data_byte;
      last_q <= last_item;
    end
    if (cmd.read_b) begin
      val_a <= box_dat;
    end
    if (cmd.write_a) begin
      val_b <= box_dat;
      eq_a  <= (box_raddr == idx_a);
      eq_j  <= (box_raddr == idx_j);
    end
  end

  // Keystream read was issued before the swap finished; forward new values
  always_comb begin
    priority if (eq_j) begin
      ks = val_a;
    end else if (eq_a) begin
      ks = val_b;
    end else begin
      ks = box_dat;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (dout_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte <= data_q ^ ks;
      out_last <= last_q;
    end
  end

  assign sts.last_step = (idx_a == BOX_LAST);
  assign sts.out_free  = ~out_valid | dout_ready;

`ifndef SYNTHESIS
  a_sched_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.sched_end |=> (idx_a == '0 && idx_j == '0 && key_count == '0))
    else $error("indices not cleared after key schedule");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || dout_ready))
    else $error("result register overwritten");

  a_key_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= KEY_CNT_W'(KEY_DEPTH))
    else $error("key count past key store depth");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher engine: key load, key schedule and keystream XOR.
// ----------------------------------------------------------------------------
// Key bytes (action 0) are taken one per cycle while idle and stored in
// order; bytes past the key store depth are dropped. The key byte that
// carries last_item also runs the key schedule, 256 rounds during which no
// item is taken. Each round and each crypt step is a chain of dependent box
// reads and a two-write swap on the box RAM (one read port, one write port),
// which sets the read, read, write, write order of the step. A crypt item
// (action 1) is accepted, walks RD_B, WR_A and WR_B, and its result is loaded
// into the output register at the end of WR_B; the next item is accepted in
// the following cycle even if that result has not been taken yet. A crypt
// result that finds the output register still full waits in its last step,
// and no item is taken until it moves. After reset the box is the identity
// permutation with no clearing pass; it is held by per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher (
  input  wire logic clk,
  input  wire logic rst,
  rc4_in_if.sink    din,
  rc4_out_if.source dout
);
  import rc4_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rc4_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .din_valid  (din.valid),
    .din_action (din.action),
    .din_last   (din.last_item),
    .din_ready  (din.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rc4_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .data_byte  (din.data_byte),
    .last_item  (din.last_item),
    .dout_ready (dout.ready),
    .out_valid  (dout.valid),
    .out_byte   (dout.out_byte),
    .out_last   (dout.out_last)
  );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for rc4_stream_cipher. Key-load and crypt
// transactions are driven on the input channel. A behavioral RC4 model
// tracks the box, the key store and both indices, and predicts each output
// byte. The output channel is checked in order, field by field. Both sides
// idle in random bursts, and the receiver holds off long enough to stall the
// engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } cipher_word_t;

  logic clk;
  logic rst;

  rc4_in_if  din_if ();
  rc4_out_if dout_if ();

  rc4_stream_cipher DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  // Cipher model state
  logic [7:0]  model_box [BOX_DEPTH];
  logic [7:0]  model_key [BOX_DEPTH];
  int unsigned model_key_len;
  logic [7:0]  model_i;
  logic [7:0]  model_j;

  cipher_word_t pending_cipher_out [$];
  int unsigned  fail_count;
  int unsigned  items_counted;

  // Idle control: bursty is shared by sender and receiver, the rest is receiver-only
  bit          bursty;
  bit          rx_hold;
  int unsigned rx_stall_left;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("rc4_stream_cipher verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Cipher model
  // --------------------------------------------------------------------------
  function automatic void box_to_identity();
    for (int n = 0; n < BOX_DEPTH; n++) model_box[n] = n[7:0];
  endfunction

  // Key schedule over the stored key, repeated cyclically
  function automatic void run_key_schedule();
    logic [7:0] j;
    logic [7:0] kb;
    logic [7:0] t;
    j = 8'h00;
    box_to_identity();
    for (int n = 0; n < BOX_DEPTH; n++) begin
      kb = (model_key_len != 0) ? model_key[n % model_key_len] : 8'h00;
      j = j + model_box[n] + kb;
      t = model_box[n];
      model_box[n] = model_box[j];
      model_box[j] = t;
    end
    model_i = 8'h00;
    model_j = 8'h00;
    model_key_len = 0;
  endfunction

  // One generator step; returns the keystream byte
  function automatic logic [7:0] next_keystream();
    logic [7:0] t;
    model_i = model_i + 8'd1;
    model_j = model_j + model_box[model_i];
    t = model_box[model_i];
    model_box[model_i] = model_box[model_j];
    model_box[model_j] = t;
    return model_box[model_box[model_i] + model_box[model_j]];
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random ready, long hold-off, in-order checking
  // --------------------------------------------------------------------------
  initial begin
    cipher_word_t want;
    dout_if.ready = 1'b0;
    rx_stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && dout_if.valid && dout_if.ready) begin
        if (pending_cipher_out.size() == 0) begin
          log_failure($sformatf("unexpected transaction: out_byte=%02h out_last=%0b",
                                dout_if.out_byte, dout_if.out_last));
        end else begin
          want = pending_cipher_out.pop_front();
          if (dout_if.out_byte !== want.text || dout_if.out_last !== want.last)
            log_failure($sformatf({"mismatch: out_byte exp %02h got %02h, ",
                                   "out_last exp %0b got %0b"},
                                  want.text, dout_if.out_byte,
                                  want.last, dout_if.out_last));
        end
      end
      // Next cycle's ready
      if (rst || rx_hold) begin
        dout_if.ready <= 1'b0;
      end else if (rx_stall_left != 0) begin
        dout_if.ready <= 1'b0;
        rx_stall_left--;
      end else if (bursty && $urandom_range(0, 4) == 0) begin
        dout_if.ready <= 1'b0;
        rx_stall_left = $urandom_range(0, 2);
      end else begin
        dout_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offers one transaction, waits for acceptance, updates the model.
  // Valid stays high on return so a following item goes out back to back.
  task automatic send_item(action_t act, logic [7:0] data, logic last);
    if (bursty && $urandom_range(0, 3) == 0) begin
      din_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.action    <= act;
    din_if.data_byte <= data;
    din_if.last_item <= last;
    do @(posedge clk); while (!din_if.ready);

    if (act == ACT_KEY) begin
      if (model_key_len < KEY_DEPTH) begin
        model_key[model_key_len] = data;
        model_key_len++;
      end
      if (last) run_key_schedule();
    end else begin
      pending_cipher_out.push_back('{text: data ^ next_keystream(), last: last});
    end
    items_counted++;
  endtask

  task automatic stop_input();
    din_if.valid <= 1'b0;
  endtask

  task automatic send_random_key(int unsigned len, bit close);
    for (int unsigned k = 0; k < len; k++)
      send_item(ACT_KEY, 8'($urandom_range(0, 255)), close && (k == len - 1));
  endtask

  task automatic send_random_message(int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_item(ACT_CRYPT, 8'($urandom_range(0, 255)), k == len - 1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Crypt on the reset box, extreme data values, last on a middle byte
  task automatic test_crypt_before_key();
    send_item(ACT_CRYPT, 8'h00, 1'b0);
    send_item(ACT_CRYPT, 8'hff, 1'b0);
    send_item(ACT_CRYPT, 8'h5a, 1'b1);
    send_item(ACT_CRYPT, 8'ha5, 1'b0);
  endtask

  // One-byte keys at both extremes
  task automatic test_single_byte_keys();
    send_item(ACT_KEY, 8'hff, 1'b1);
    send_item(ACT_CRYPT, 8'h00, 1'b0);
    send_item(ACT_CRYPT, 8'hff, 1'b1);
    send_item(ACT_KEY, 8'h00, 1'b1);
    send_item(ACT_CRYPT, 8'h3c, 1'b0);
    send_item(ACT_CRYPT, 8'hc3, 1'b1);
  endtask

  // Multi-byte key; last on a crypt byte must not reset the generator
  task automatic test_multi_byte_key();
    send_item(ACT_KEY, 8'h01, 1'b0);
    send_item(ACT_KEY, 8'h80, 1'b0);
    send_item(ACT_KEY, 8'hff, 1'b0);
    send_item(ACT_KEY, 8'h00, 1'b0);
    send_item(ACT_KEY, 8'h7f, 1'b1);
    send_item(ACT_CRYPT, 8'h11, 1'b0);
    send_item(ACT_CRYPT, 8'h22, 1'b1);
    send_item(ACT_CRYPT, 8'h44, 1'b0);
    send_item(ACT_CRYPT, 8'h88, 1'b0);
    send_item(ACT_CRYPT, 8'hf0, 1'b1);
  endtask

  // Key longer than the store: extra bytes dropped, last still schedules
  task automatic test_overlong_key();
    send_random_key(KEY_DEPTH + 2, 1'b1);
    send_random_message(6);
  endtask

  // Receiver holds off while crypt transactions keep coming
  task automatic test_result_backpressure();
    bursty <= 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_random_message(40);
  endtask

  // Mostly well-formed key/message sequences, with noise and broken ones
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    start = items_counted;
    while (items_counted - start < 576) begin
      if (items_counted - start < 480)
        bursty <= ($urandom_range(0, 3) != 0);
      else
        bursty <= 1'b0;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // noise: any field values
        repeat ($urandom_range(1, 8))
          send_item(action_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end else if (pick == 1) begin
        // broken: key left open, crypt in between
        send_random_key($urandom_range(1, 6), 1'b0);
        send_random_message($urandom_range(1, 6));
      end else begin
        pick = $urandom_range(0, 29);
        if (pick == 0)      len = KEY_DEPTH;
        else if (pick == 1) len = $urandom_range(KEY_DEPTH + 1, KEY_DEPTH + 8);
        else if (pick < 4)  len = $urandom_range(17, KEY_DEPTH - 1);
        else                len = $urandom_range(1, 16);
        send_random_key(len, 1'b1);
        send_random_message($urandom_range(1, 40));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    din_if.valid     = 1'b0;
    din_if.action    = ACT_KEY;
    din_if.data_byte = 8'h00;
    din_if.last_item = 1'b0;
    bursty           = 1'b0;
    rx_hold          = 1'b0;
    fail_count       = 0;
    items_counted    = 0;
    model_key_len    = 0;
    model_i          = 8'h00;
    model_j          = 8'h00;
    for (int n = 0; n < BOX_DEPTH; n++) model_key[n] = 8'h00;
    box_to_identity();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    bursty <= 1'b1;
    test_crypt_before_key();
    test_single_byte_keys();
    test_multi_byte_key();
    test_overlong_key();
    test_result_backpressure();
    test_random_traffic();
    stop_input();

    // Drain, then keep watching for anything stray
    while (pending_cipher_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending_cipher_out.size() == 0) begin
      $display("rc4_stream_cipher verification clean");
    end else begin
      $display("rc4_stream_cipher verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: rc4_stream_cipher.f
rtl/core/rc4_pkg.sv
rtl/core/rc4_if.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_ctrl.sv
rtl/core/rc4_dp.sv
rtl/core/rc4_stream_cipher.sv
dv/tb_top.sv
